@@ hdl/fst_pkg.sv @@
// fst_pkg: shared types for the free-list slot table.
// Holds the command and status structs that join the controller and the datapath.
// No dependencies.
`default_nettype none

package fst_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // load the accepted item
        logic rd;       // issue the memory reads
        logic eval;     // evaluate read data, write back, update result
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_more;  // search row held no hit and another row remains
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/freelist_slot_table.sv @@
// freelist_slot_table: top level of the free-list slot table.
// Instantiates fst_ctrl (sequencer) and fst_datapath (storage and logic); uses fst_pkg.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one operation (i_op, i_slot_index,
//   i_write_value); output channel o_out_valid / i_out_ready returns one result
//   (o_status, o_result_index, o_read_value, o_found) for every operation, in order.
//   A transfer happens on a rising edge with valid and ready both high.
//   One operation is in flight at a time: accept, read, evaluate, present.
//   Insert, erase, read and clear pass once through read and evaluation before the
//   result is presented. Next-valid and prev-valid scan the valid bits 32 slots per
//   row, each further row costing a row read plus an evaluation on the single
//   valid-bit memory port.
//   While the receiver stalls, the result is held on the output and no new
//   operation is taken.
//   Reset (synchronous, active low) holds o_in_ready low and empties the table and
//   free list at once; no clearing pass is needed, and the slot store keeps no reset value.
`default_nettype none

module freelist_slot_table #(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_op,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_slot_index,
    input  wire logic [VALUE_WIDTH-1:0]        i_write_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status,
    output logic [$clog2(CAPACITY+1)-1:0]      o_result_index,
    output logic [VALUE_WIDTH-1:0]             o_read_value,
    output logic                               o_found
);

    fst_pkg::t_cmd w_cmd;
    fst_pkg::t_sts w_sts;

    // Sequencer
    fst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Storage and operation logic
    fst_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_op),
        .i_slot_index   (i_slot_index),
        .i_write_value  (i_write_value),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .o_read_value   (o_read_value),
        .o_found        (o_found)
    );

endmodule

`default_nettype wire

@@ hdl/fst_ctrl.sv @@
// fst_ctrl: sequencing state machine of the free-list slot table.
// Drives the datapath through fst_pkg::t_cmd and reads back fst_pkg::t_sts.
// Depends on fst_pkg.
`default_nettype none

module fst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fst_pkg::t_cmd      o_cmd,
    input  wire fst_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode the state into handshake and datapath commands; refuse input in reset
    always_comb begin
        o_in_ready    = (r_state == S_IDLE) && i_rst_n;
        o_out_valid   = (r_state == S_OUT);
        o_cmd.capture = (r_state == S_IDLE) && i_rst_n && i_in_valid;
        o_cmd.rd      = (r_state == S_READ);
        o_cmd.eval    = (r_state == S_EVAL);
    end

    // Advance: accept, read, evaluate (looping over search rows), present
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.scan_more) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; return to idle on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_eval_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.eval && !i_sts.scan_more) |=> o_out_valid)
        else $error("finished evaluation did not present a result");

    a_scan_rereads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.eval && i_sts.scan_more) |=> (o_cmd.rd && !o_out_valid))
        else $error("search continuation did not issue a new row read");

endmodule

`default_nettype wire

@@ hdl/fst_datapath.sv @@
// fst_datapath: slot store, valid-bit rows, free-list head and high-water mark.
// Executes one operation per controller command sequence and holds the result.
// Depends on fst_pkg.
`default_nettype none

module fst_datapath #(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fst_pkg::t_cmd                  i_cmd,
    output fst_pkg::t_sts                       o_sts,
    input  wire logic [2:0]                     i_op,
    input  wire logic [$clog2(CAPACITY)-1:0]    i_slot_index,
    input  wire logic [VALUE_WIDTH-1:0]         i_write_value,
    output logic [1:0]                          o_status,
    output logic [$clog2(CAPACITY+1)-1:0]       o_result_index,
    output logic [VALUE_WIDTH-1:0]              o_read_value,
    output logic                                o_found
);

    localparam int IW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int XW       = IW + 1;
    localparam int VW       = VALUE_WIDTH;
    localparam int LW       = (VW > CW) ? VW : CW;
    localparam int DEPTH    = 1 << IW;
    localparam int ROW_MAX  = 32;
    localparam int ROW_W    = (DEPTH < ROW_MAX) ? DEPTH : ROW_MAX;
    localparam int ROW_BITS = $clog2(ROW_W);
    localparam int ROWS     = DEPTH / ROW_W;
    localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_NEXT   = 3'd3;
    localparam logic [2:0] OP_PREV   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Storage
    logic [VW-1:0]    r_slot_mem  [DEPTH];
    logic [ROW_W-1:0] r_valid_mem [ROWS];

    // Item and scan registers
    logic [2:0]       r_op;
    logic [IW-1:0]    r_idx;
    logic [VW-1:0]    r_wval;
    logic [RAW-1:0]   r_row;
    logic             r_first;
    logic             r_hit;
    logic [VW-1:0]    r_slot_q;
    logic [ROW_W-1:0] r_row_q;

    // Table state
    logic [CW-1:0]    r_used;
    logic [CW-1:0]    r_head;

    // Result registers
    logic [1:0]       r_status;
    logic [CW-1:0]    r_res_idx;
    logic [VW-1:0]    r_rd_val;
    logic             r_found;

    // Next values
    logic [CW-1:0]    n_used;
    logic [CW-1:0]    n_head;
    logic [1:0]       n_status;
    logic [CW-1:0]    n_res_idx;
    logic [VW-1:0]    n_rd_val;
    logic             n_found;
    logic [RAW-1:0]   n_row;

    // Combinational datapath
    logic                w_head_free;
    logic                w_room;
    logic                w_is_scan;
    logic                w_is_next;
    logic [IW-1:0]       w_slot;
    logic [RAW-1:0]      w_slot_row;
    logic [RAW-1:0]      w_rd_row;
    logic [ROW_BITS-1:0] w_idx_pos;
    logic                w_hit;
    logic [XW-1:0]       w_base;
    logic [XW-1:0]       w_base_end;
    logic [XW-1:0]       w_used_x;
    logic [ROW_W-1:0]    w_range;
    logic [ROW_W-1:0]    w_above;
    logic [ROW_W-1:0]    w_below;
    logic [ROW_W-1:0]    w_cand;
    logic                w_any;
    logic [ROW_BITS-1:0] w_lo_pos;
    logic [ROW_BITS-1:0] w_hi_pos;
    logic [XW-1:0]       w_found_x;
    logic                w_more;
    logic [LW-1:0]       w_link_x;
    logic [CW-1:0]       w_new_head;
    logic                w_slot_we;
    logic [VW-1:0]       w_slot_wd;
    logic                w_row_we;
    logic [ROW_W-1:0]    w_row_wd;

    // Select the addressed slot and the valid row to read
    always_comb begin
        w_head_free = (r_head < CW'(CAPACITY));
        w_room      = (r_used < CW'(CAPACITY));
        w_is_next   = (r_op == OP_NEXT);
        w_is_scan   = (r_op == OP_NEXT) || (r_op == OP_PREV);
        if (r_op == OP_INSERT) begin
            w_slot = w_head_free ? IW'(r_head) : IW'(r_used);
        end else begin
            w_slot = r_idx;
        end
        w_slot_row = RAW'(w_slot >> ROW_BITS);
        w_rd_row   = w_is_scan ? r_row : w_slot_row;
        w_idx_pos  = r_idx[ROW_BITS-1:0];
        w_used_x   = XW'(r_used);
        w_hit      = (XW'(r_idx) < w_used_x) && r_row_q[w_idx_pos];
    end

    // Mask the row being searched and find the nearest candidate
    always_comb begin
        w_base     = XW'(r_row) << ROW_BITS;
        w_base_end = w_base + XW'(ROW_W);
        for (int b = 0; b < ROW_W; b++) begin
            if (w_base_end <= w_used_x) begin
                w_range[b] = 1'b1;
            end else if (w_base >= w_used_x) begin
                w_range[b] = 1'b0;
            end else begin
                w_range[b] = (ROW_BITS'(b) < r_used[ROW_BITS-1:0]);
            end
            w_above[b] = (ROW_BITS'(b) > w_idx_pos);
            w_below[b] = (ROW_BITS'(b) < w_idx_pos);
        end
        if (!r_first) begin
            w_cand = r_row_q & w_range;
        end else if (w_is_next) begin
            w_cand = r_row_q & w_range & w_above;
        end else begin
            w_cand = r_row_q & w_range & w_below;
        end
        w_any    = |w_cand;
        w_lo_pos = '0;
        w_hi_pos = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_lo_pos = ROW_BITS'(b);
            end
        end
        for (int b = 0; b < ROW_W; b++) begin
            if (w_cand[b]) begin
                w_hi_pos = ROW_BITS'(b);
            end
        end
        w_found_x = w_base | XW'(w_is_next ? w_lo_pos : w_hi_pos);
        w_more    = w_is_next ? (w_base_end < w_used_x) : (r_row != '0);
        o_sts.scan_more = w_is_scan && !w_any && w_more;
    end

    // Follow the free-list link; a link past the capacity ends the list
    always_comb begin
        w_link_x   = LW'(r_slot_q);
        w_new_head = (w_link_x > LW'(CAPACITY)) ? CW'(CAPACITY) : CW'(w_link_x);
    end

    // Work out the operation: result, state update and write-back
    always_comb begin
        n_used    = r_used;
        n_head    = r_head;
        n_status  = ST_NONE;
        n_res_idx = CW'(CAPACITY);
        n_rd_val  = '0;
        n_found   = 1'b0;
        n_row     = r_row;
        w_slot_we = 1'b0;
        w_slot_wd = r_wval;
        w_row_we  = 1'b0;
        w_row_wd  = r_row_q;
        case (r_op)
            OP_INSERT: begin
                if (w_head_free || w_room) begin
                    w_slot_we                     = 1'b1;
                    w_row_we                      = 1'b1;
                    w_row_wd[w_slot[ROW_BITS-1:0]] = 1'b1;
                    n_status                      = ST_OK;
                    n_res_idx                     = CW'(w_slot);
                    if (w_head_free) begin
                        n_head = w_new_head;
                    end else begin
                        n_used = r_used + CW'(1);
                    end
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_ERASE: begin
                if (w_hit) begin
                    w_slot_we           = 1'b1;
                    w_slot_wd           = VW'(r_head);
                    w_row_we            = 1'b1;
                    w_row_wd[w_idx_pos] = 1'b0;
                    n_head              = CW'(r_idx);
                    n_status            = ST_OK;
                    n_res_idx           = CW'(r_idx);
                    n_found             = 1'b1;
                end
            end
            OP_READ: begin
                if (w_hit) begin
                    n_status  = ST_OK;
                    n_res_idx = CW'(r_idx);
                    n_rd_val  = r_slot_q;
                    n_found   = 1'b1;
                end
            end
            OP_NEXT, OP_PREV: begin
                n_found = r_first ? w_hit : r_hit;
                if (w_any) begin
                    n_status  = ST_OK;
                    n_res_idx = CW'(w_found_x);
                end else if (w_more) begin
                    n_row = w_is_next ? (r_row + RAW'(1)) : (r_row - RAW'(1));
                end
            end
            OP_CLEAR: begin
                n_used   = '0;
                n_head   = CW'(CAPACITY);
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_NONE;
            end
        endcase
    end

    // Slot store: registered read, write-back on evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_slot_q <= r_slot_mem[w_slot];
        end
        if (i_cmd.eval && w_slot_we) begin
            r_slot_mem[w_slot] <= w_slot_wd;
        end
    end

    // Valid rows: registered read, read-modify-write on evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_row_q <= r_valid_mem[w_rd_row];
        end
        if (i_cmd.eval && w_row_we) begin
            r_valid_mem[w_slot_row] <= w_row_wd;
        end
    end

    // Capture the item; advance the search row and update the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_idx   <= i_slot_index;
            r_wval  <= i_write_value;
            r_row   <= RAW'(i_slot_index >> ROW_BITS);
            r_first <= 1'b1;
        end else if (i_cmd.eval) begin
            r_row     <= n_row;
            r_first   <= 1'b0;
            r_status  <= n_status;
            r_res_idx <= n_res_idx;
            r_rd_val  <= n_rd_val;
            r_found   <= n_found;
            if (r_first) begin
                r_hit <= w_hit;
            end
        end
    end

    // High-water mark and free-list head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_head <= CW'(CAPACITY);
        end else if (i_cmd.eval) begin
            r_used <= n_used;
            r_head <= n_head;
        end
    end

    assign o_status       = r_status;
    assign o_result_index = r_res_idx;
    assign o_read_value   = r_rd_val;
    assign o_found        = r_found;

    a_state_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used <= CW'(CAPACITY)) && (r_head <= CW'(CAPACITY)))
        else $error("used count or free-list head beyond capacity");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && w_is_scan && w_any) |-> (w_found_x < w_used_x))
        else $error("search hit at or above the used count");

endmodule

`default_nettype wire

@@ bench/freelist_slot_table_test.sv @@
// freelist_slot_table_test: self-checking bench for the free-list slot table.
// Holds a shadow copy of the table, random valid/ready drivers and the result checker.
// Depends on hdl/freelist_slot_table.sv and hdl/fst_pkg.sv.
`timescale 1ns / 100ps

module freelist_slot_table_test;

    localparam int CAPACITY      = 1024;
    localparam int VALUE_W       = 32;
    localparam int IDX_W         = 10;
    localparam int RIDX_W        = 11;
    localparam int SETTLE_CYCLES = 80;
    localparam int CHURN_ITEMS   = 360;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_ERASE   = 3'd1,
        OP_READ    = 3'd2,
        OP_NEXT    = 3'd3,
        OP_PREV    = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_SPARE_A = 3'd6,
        OP_SPARE_B = 3'd7
    } t_table_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_table_status;

    typedef struct packed {
        t_table_status       status;
        logic [RIDX_W-1:0]   index;
        logic [VALUE_W-1:0]  value;
        logic                found;
    } t_table_result;

    // Shadow of the slot table: predicts each result and checks the block against it
    class t_slot_table_shadow;
        logic [VALUE_W-1:0] store [CAPACITY];
        bit                 valid_flag [CAPACITY];
        int unsigned        used_count;
        int unsigned        free_head;
        t_table_result      due_results [$];
        int unsigned        mismatches;

        function new();
            foreach (valid_flag[i]) begin
                valid_flag[i] = 1'b0;
                store[i]      = '0;
            end
            used_count = 0;
            free_head  = CAPACITY;
            mismatches = 0;
        endfunction

        // A slot at or above the high-water mark is dead whatever its flag says
        function bit slot_live(int unsigned i);
            return i < used_count && i < CAPACITY && valid_flag[i];
        endfunction

        function void note_transfer(t_table_op op, logic [IDX_W-1:0] idx,
                                    logic [VALUE_W-1:0] wval);
            t_table_result r;
            bit            hit;
            bit            got;
            int unsigned   i;
            int unsigned   slot;
            int unsigned   link;
            hit      = slot_live(idx);
            got      = 1'b0;
            r.status = ST_MISS;
            r.index  = RIDX_W'(CAPACITY);
            r.value  = '0;
            r.found  = 1'b0;
            case (op)
                OP_INSERT: begin
                    if (free_head < CAPACITY) begin
                        // pop the most recently freed slot; a wild link ends the list
                        slot      = free_head;
                        link      = store[slot];
                        free_head = (link > CAPACITY) ? CAPACITY : link;
                        store[slot]      = wval;
                        valid_flag[slot] = 1'b1;
                        r.status = ST_OK;
                        r.index  = RIDX_W'(slot);
                    end else if (used_count < CAPACITY) begin
                        slot             = used_count;
                        store[slot]      = wval;
                        valid_flag[slot] = 1'b1;
                        used_count++;
                        r.status = ST_OK;
                        r.index  = RIDX_W'(slot);
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                OP_ERASE: begin
                    if (hit) begin
                        valid_flag[idx] = 1'b0;
                        store[idx]      = VALUE_W'(free_head);
                        free_head       = idx;
                        r.status = ST_OK;
                        r.index  = RIDX_W'(idx);
                        r.found  = 1'b1;
                    end
                end
                OP_READ: begin
                    if (hit) begin
                        r.status = ST_OK;
                        r.index  = RIDX_W'(idx);
                        r.value  = store[idx];
                        r.found  = 1'b1;
                    end
                end
                OP_NEXT: begin
                    i = idx + 1;
                    while (i < used_count && !slot_live(i))
                        i++;
                    if (i < used_count) begin
                        r.status = ST_OK;
                        r.index  = RIDX_W'(i);
                    end
                    r.found = hit;
                end
                OP_PREV: begin
                    i = (idx < used_count) ? idx : used_count;
                    while (i > 0 && !got) begin
                        i--;
                        got = slot_live(i);
                    end
                    if (got) begin
                        r.status = ST_OK;
                        r.index  = RIDX_W'(i);
                    end
                    r.found = hit;
                end
                OP_CLEAR: begin
                    used_count = 0;
                    free_head  = CAPACITY;
                    r.status   = ST_OK;
                end
                default: ;
            endcase
            due_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [RIDX_W-1:0] ri,
                                   logic [VALUE_W-1:0] rv, logic fd);
            t_table_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d index %0d value %h found %0d",
                         $time, st, ri, rv, fd);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (st !== want.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, want.status, st);
                mismatches++;
            end
            if (ri !== want.index) begin
                $display("%0t: result_index expected %0d, actual %0d",
                         $time, want.index, ri);
                mismatches++;
            end
            if (rv !== want.value) begin
                $display("%0t: read_value expected %h, actual %h", $time, want.value, rv);
                mismatches++;
            end
            if (fd !== want.found) begin
                $display("%0t: found expected %0d, actual %0d", $time, want.found, fd);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [2:0]         op_bus    = '0;
    logic [IDX_W-1:0]   slot_bus  = '0;
    logic [VALUE_W-1:0] value_bus = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status_bus;
    logic [RIDX_W-1:0]  ridx_bus;
    logic [VALUE_W-1:0] rval_bus;
    logic               found_bus;
    bit                 calm      = 1'b0;

    t_slot_table_shadow shadow = new();

    freelist_slot_table #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_W)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (op_bus),
        .i_slot_index   (slot_bus),
        .i_write_value  (value_bus),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status_bus),
        .o_result_index (ridx_bus),
        .o_read_value   (rval_bus),
        .o_found        (found_bus)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long; none while calm
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Favour slots under the high-water mark, then around it, the ends and the full range
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned r;
        int          near;
        r = $urandom_range(0, 99);
        if (r < 65 && shadow.used_count > 0)
            return IDX_W'($urandom_range(0, shadow.used_count - 1));
        if (r < 80) begin
            near = int'(shadow.used_count) - 2 + int'($urandom_range(0, 4));
            if (near < 0)
                near = 0;
            if (near > CAPACITY - 1)
                near = CAPACITY - 1;
            return IDX_W'(near);
        end
        if (r < 88)
            return ($urandom_range(0, 1) != 0) ? IDX_W'(CAPACITY - 1) : '0;
        return IDX_W'($urandom);
    endfunction

    function automatic t_table_op pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_INSERT;
        if (r < 55) return OP_ERASE;
        if (r < 73) return OP_READ;
        if (r < 84) return OP_NEXT;
        if (r < 95) return OP_PREV;
        if (r < 97) return OP_CLEAR;
        return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    // Present one operation after a random gap and hold it until the transfer
    task automatic send_op(t_table_op op, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] wval);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op_bus    <= op;
        slot_bus  <= idx;
        value_bus <= wval;
        do @(posedge clk); while (!in_ready);
        shadow.note_transfer(op, idx, wval);
    endtask

    // Receiver side: random stalls, with calm stretches
    initial begin
        int unsigned stall;
        int unsigned hold;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            hold = $urandom_range(1, 6);
            repeat (hold) @(posedge clk);
        end
    end

    // Check every result transfer
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            shadow.check_result(status_bus, ridx_bus, rval_bus, found_bus);
    end

    initial begin
        int unsigned churned;
        int unsigned n;
        churned = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: every lookup misses
        send_op(OP_READ, '0, '0);
        send_op(OP_NEXT, '0, '0);
        send_op(OP_PREV, IDX_W'(CAPACITY - 1), '0);
        send_op(OP_ERASE, IDX_W'(CAPACITY - 1), '0);
        // Append at the high-water mark, value extremes
        send_op(OP_INSERT, '0, 32'h0000_0000);
        send_op(OP_INSERT, IDX_W'(CAPACITY - 1), 32'hFFFF_FFFF);
        send_op(OP_INSERT, '0, 32'hA5A5_A5A5);
        send_op(OP_INSERT, '0, 32'h5A5A_5A5A);
        send_op(OP_READ, 10'd1, '0);
        send_op(OP_READ, 10'd3, '0);
        // Free two slots, then erase and read a dead one
        send_op(OP_ERASE, 10'd1, '0);
        send_op(OP_ERASE, 10'd2, '0);
        send_op(OP_ERASE, 10'd1, '0);
        send_op(OP_READ, 10'd1, '0);
        // Searches skip dead slots; prev clamps at the high-water mark
        send_op(OP_NEXT, 10'd0, '0);
        send_op(OP_PREV, 10'd3, '0);
        send_op(OP_PREV, IDX_W'(CAPACITY - 1), '0);
        send_op(OP_NEXT, IDX_W'(CAPACITY - 1), '0);
        // Reuse in LIFO order, then append again
        send_op(OP_INSERT, '0, 32'h1234_5678);
        send_op(OP_INSERT, '0, 32'h8765_4321);
        send_op(OP_INSERT, '0, 32'hDEAD_BEEF);
        send_op(OP_SPARE_A, IDX_W'(CAPACITY - 1), 32'hFFFF_FFFF);
        send_op(OP_SPARE_B, '0, '0);
        // Clear leaves stale valid flags that must read as dead
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_READ, 10'd0, '0);
        send_op(OP_PREV, IDX_W'(CAPACITY - 1), '0);

        // Random churn in bursts
        while (churned < CHURN_ITEMS) begin
            n    = $urandom_range(20, 60);
            calm = ($urandom_range(0, 4) == 0);
            repeat (n) send_op(pick_op(), pick_index(), $urandom);
            churned += n;
            calm = 1'b0;
        end
        in_valid <= 1'b0;

        // Drain, then allow for any stray result
        while (shadow.due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
